// ===== src/fpmo_pkg.sv =====
// package: types, constants and helpers for the five point marker ordering block
`timescale 1ns / 1ps
`default_nettype none
package fpmo_pkg;
   localparam int COORD_BITS = 16;
   localparam int NPTS = 5;
   localparam int IDX_BITS = 3;
   localparam int SQ_BITS = 2 * COORD_BITS + 1;
   localparam int PROD_BITS = 2 * COORD_BITS;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [IDX_BITS-1:0] idx_type;
   typedef logic [SQ_BITS-1:0] sq_type;

   typedef struct packed {
      coord_type x0; coord_type y0;
      coord_type x1; coord_type y1;
      coord_type x2; coord_type y2;
      coord_type x3; coord_type y3;
      coord_type x4; coord_type y4;
   } req_type;

   typedef struct packed {
      coord_type led0_x; coord_type led0_y;
      coord_type led1_x; coord_type led1_y;
      coord_type led2_x; coord_type led2_y;
      coord_type led3_x; coord_type led3_y;
      coord_type led4_x; coord_type led4_y;
   } rsp_type;

   typedef coord_type [NPTS-1:0] pts_type;

   function automatic coord_type absdiff(input coord_type u, input coord_type v);
      return (u < v) ? coord_type'(v - u) : coord_type'(u - v);
   endfunction
endpackage
`default_nettype wire

// ===== src/fpmo_sqlane.sv =====
// squared distance lane: one point pair per lane, registered result
`timescale 1ns / 1ps
`default_nettype none
module fpmo_sqlane (
   input  wire logic                  clock,
   input  wire logic                  en,
   input  wire fpmo_pkg::coord_type  ax,
   input  wire fpmo_pkg::coord_type  ay,
   input  wire fpmo_pkg::coord_type  bx,
   input  wire fpmo_pkg::coord_type  by,
   output fpmo_pkg::sq_type          dist_ff
);
   fpmo_pkg::coord_type dx, dy;
   logic [fpmo_pkg::PROD_BITS-1:0] mx_ff, my_ff;
   fpmo_pkg::sq_type dist_in;
   assign dx = fpmo_pkg::absdiff(ax, bx);
   assign dy = fpmo_pkg::absdiff(ay, by);
   assign dist_in = fpmo_pkg::sq_type'(mx_ff) + fpmo_pkg::sq_type'(my_ff);
   always_ff @(posedge clock) begin
      if (en) begin
         mx_ff   <= dx * dx;
         my_ff   <= dy * dy;
         dist_ff <= dist_in;
      end
   end
endmodule
`default_nettype wire

// ===== src/fpmo_crosslane.sv =====
// cross product magnitude lane: |(b-a) x (p-a)|, registered
`timescale 1ns / 1ps
`default_nettype none
module fpmo_crosslane (
   input  wire logic                  clock,
   input  wire logic                  en,
   input  wire fpmo_pkg::coord_type  ax,
   input  wire fpmo_pkg::coord_type  ay,
   input  wire fpmo_pkg::coord_type  bx,
   input  wire fpmo_pkg::coord_type  by,
   input  wire fpmo_pkg::coord_type  px,
   input  wire fpmo_pkg::coord_type  py,
   output fpmo_pkg::sq_type          mag_ff
);
   logic [fpmo_pkg::PROD_BITS-1:0] m1_ff, m2_ff;
   logic s_ff;
   logic n1, n2, n3, n4, s1, s2;
   fpmo_pkg::sq_type mag_in;
   logic [fpmo_pkg::PROD_BITS-1:0] m1, m2;
   assign n1 = bx < ax;
   assign n2 = py < ay;
   assign n3 = by < ay;
   assign n4 = px < ax;
   assign m1 = fpmo_pkg::absdiff(bx, ax) * fpmo_pkg::absdiff(py, ay);
   assign m2 = fpmo_pkg::absdiff(by, ay) * fpmo_pkg::absdiff(px, ax);
   assign s1 = (n1 != n2) && (m1 != '0);
   assign s2 = (n3 != n4) && (m2 != '0);
   // same sign: difference, else sum of magnitudes
   always_comb begin
      if (!s_ff)
         mag_in = (m1_ff >= m2_ff) ? fpmo_pkg::sq_type'(m1_ff - m2_ff)
                                   : fpmo_pkg::sq_type'(m2_ff - m1_ff);
      else
         mag_in = fpmo_pkg::sq_type'(m1_ff) + fpmo_pkg::sq_type'(m2_ff);
   end
   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff  <= m1;
         m2_ff  <= m2;
         s_ff   <= (s1 != s2);
         mag_ff <= mag_in;
      end
   end
endmodule
`default_nettype wire

// ===== src/five_point_marker_ordering.sv =====
// top level: five point marker ordering pipeline
`timescale 1ns / 1ps
`default_nettype none
// Orders five blob centroids into the marker numbering. Fully pipelined over
// nine stages: a word can be taken every cycle and its result is offered on
// the rsp side once it has moved through stage 8. Stage 0 holds
// the input word, stages 1-2 are ten pair distance lanes (multiply register,
// sum register), stage 3 picks the closest pair, stages 4-5 are three cross
// product lanes, stage 6 picks point 1, stages 7-8 are five final distance
// lanes, and the ordered points are muxed out of stage 8. Throughput is one
// word per cycle while results are taken; while a finished result waits the
// whole pipe holds, and req_ready follows rsp_ready in that cycle.
module five_point_marker_ordering (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire fpmo_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output fpmo_pkg::rsp_type      rsp_data
);
   localparam int DEPTH = 9;
   localparam int NPAIR = 10;
   localparam int NREST = 3;
   localparam int NFIN = 5;

   // pair table in scan order 01,02,03,04,12,13,14,23,24,34
   function automatic fpmo_pkg::idx_type pair_lo(input logic [3:0] g);
      case (g)
         4'd0, 4'd1, 4'd2, 4'd3: pair_lo = 3'd0;
         4'd4, 4'd5, 4'd6: pair_lo = 3'd1;
         4'd7, 4'd8: pair_lo = 3'd2;
         default: pair_lo = 3'd3;
      endcase
   endfunction

   function automatic fpmo_pkg::idx_type pair_hi(input logic [3:0] g);
      case (g)
         4'd0: pair_hi = 3'd1;
         4'd1, 4'd4: pair_hi = 3'd2;
         4'd2, 4'd5, 4'd7: pair_hi = 3'd3;
         default: pair_hi = 3'd4;
      endcase
   endfunction

   logic [DEPTH-1:0] vld_ff;
   logic advance;
   // pipe moves when the last stage is empty or being taken
   assign advance   = !vld_ff[DEPTH-1] || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = vld_ff[DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= {vld_ff[DEPTH-2:0], req_valid};
   end

   // point arrays carried down the pipe
   fpmo_pkg::pts_type px_in, py_in;
   fpmo_pkg::pts_type px_ff [DEPTH];
   fpmo_pkg::pts_type py_ff [DEPTH];
   assign px_in = {req_data.x4, req_data.x3, req_data.x2, req_data.x1, req_data.x0};
   assign py_in = {req_data.y4, req_data.y3, req_data.y2, req_data.y1, req_data.y0};

   always_ff @(posedge clock) begin
      if (advance) begin
         px_ff[0] <= px_in;
         py_ff[0] <= py_in;
         for (int s = 1; s < DEPTH; s++) begin
            px_ff[s] <= px_ff[s-1];
            py_ff[s] <= py_ff[s-1];
         end
      end
   end

   // stages 1-2: pair distance lanes, held with the pipe
   fpmo_pkg::sq_type pd [NPAIR];
   for (genvar g = 0; g < NPAIR; g++) begin : g_pair
      fpmo_sqlane u_sq (
         .clock   (clock),
         .en      (advance),
         .ax      (px_ff[0][pair_lo(4'(g))]),
         .ay      (py_ff[0][pair_lo(4'(g))]),
         .bx      (px_ff[0][pair_hi(4'(g))]),
         .by      (py_ff[0][pair_hi(4'(g))]),
         .dist_ff (pd[g])
      );
   end

   // closest pair merge: a tree where the left (earlier) side keeps ties
   logic [3:0] w1 [NPAIR/2];
   logic [3:0] w2 [3];
   logic [3:0] w3 [2];
   logic [3:0] win;
   always_comb begin
      for (int i = 0; i < NPAIR / 2; i++)
         w1[i] = (pd[2*i+1] < pd[2*i]) ? 4'(2*i+1) : 4'(2*i);
      w2[0] = (pd[w1[1]] < pd[w1[0]]) ? w1[1] : w1[0];
      w2[1] = (pd[w1[3]] < pd[w1[2]]) ? w1[3] : w1[2];
      w2[2] = w1[4];
      w3[0] = (pd[w2[1]] < pd[w2[0]]) ? w2[1] : w2[0];
      w3[1] = w2[2];
      win   = (pd[w3[1]] < pd[w3[0]]) ? w3[1] : w3[0];
   end

   fpmo_pkg::idx_type a_ff [3:DEPTH-1];
   fpmo_pkg::idx_type b_ff [3:DEPTH-1];
   fpmo_pkg::idx_type rest_in [NREST];
   fpmo_pkg::idx_type rest_ff [4:5][NREST];
   logic [3:0] mid_sum;

   // remaining points in input order; a is always below b
   always_comb begin
      if (a_ff[3] != 3'd0) rest_in[0] = 3'd0;
      else if (b_ff[3] != 3'd1) rest_in[0] = 3'd1;
      else rest_in[0] = 3'd2;
      if (b_ff[3] != 3'd4) rest_in[2] = 3'd4;
      else if (a_ff[3] != 3'd3) rest_in[2] = 3'd3;
      else rest_in[2] = 3'd2;
      // indices 0..4 sum to ten, so the middle one is what is left
      mid_sum = 4'd10 - {1'b0, a_ff[3]} - {1'b0, b_ff[3]}
                      - {1'b0, rest_in[0]} - {1'b0, rest_in[2]};
      rest_in[1] = mid_sum[2:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_ff[3] <= pair_lo(win);
         b_ff[3] <= pair_hi(win);
         for (int s = 4; s < DEPTH; s++) begin
            a_ff[s] <= a_ff[s-1];
            b_ff[s] <= b_ff[s-1];
         end
         for (int i = 0; i < NREST; i++) begin
            rest_ff[4][i] <= rest_in[i];
            rest_ff[5][i] <= rest_ff[4][i];
         end
      end
   end

   // stages 4-5: cross product magnitude of each remaining point against line ab
   fpmo_pkg::sq_type mag [NREST];
   for (genvar g = 0; g < NREST; g++) begin : g_cross
      fpmo_crosslane u_cross (
         .clock  (clock),
         .en     (advance),
         .ax     (px_ff[3][a_ff[3]]),
         .ay     (py_ff[3][a_ff[3]]),
         .bx     (px_ff[3][b_ff[3]]),
         .by     (py_ff[3][b_ff[3]]),
         .px     (px_ff[3][rest_in[g]]),
         .py     (py_ff[3][rest_in[g]]),
         .mag_ff (mag[g])
      );
   end

   // point 1: first minimum of the three cross products
   logic near1;
   fpmo_pkg::sq_type mag01;
   logic [1:0] k_in;
   fpmo_pkg::idx_type p1_in, r_in, s_in;
   assign near1 = mag[1] < mag[0];
   assign mag01 = near1 ? mag[1] : mag[0];
   assign k_in  = (mag[2] < mag01) ? 2'd2 : (near1 ? 2'd1 : 2'd0);

   always_comb begin
      case (k_in)
         2'd0: begin
            p1_in = rest_ff[5][0]; r_in = rest_ff[5][1]; s_in = rest_ff[5][2];
         end
         2'd1: begin
            p1_in = rest_ff[5][1]; r_in = rest_ff[5][0]; s_in = rest_ff[5][2];
         end
         default: begin
            p1_in = rest_ff[5][2]; r_in = rest_ff[5][0]; s_in = rest_ff[5][1];
         end
      endcase
   end

   fpmo_pkg::idx_type p1_ff [6:DEPTH-1];
   fpmo_pkg::idx_type r_ff [6:DEPTH-1];
   fpmo_pkg::idx_type s_ff [6:DEPTH-1];
   always_ff @(posedge clock) begin
      if (advance) begin
         p1_ff[6] <= p1_in;
         r_ff[6]  <= r_in;
         s_ff[6]  <= s_in;
         for (int s = 7; s < DEPTH; s++) begin
            p1_ff[s] <= p1_ff[s-1];
            r_ff[s]  <= r_ff[s-1];
            s_ff[s]  <= s_ff[s-1];
         end
      end
   end

   // stages 7-8: p1-a, p1-b, r-p1, r-a, r-b; r-p3 is picked later
   fpmo_pkg::idx_type fu [NFIN];
   fpmo_pkg::idx_type fv [NFIN];
   assign fu[0] = p1_ff[6]; assign fv[0] = a_ff[6];
   assign fu[1] = p1_ff[6]; assign fv[1] = b_ff[6];
   assign fu[2] = r_ff[6];  assign fv[2] = p1_ff[6];
   assign fu[3] = r_ff[6];  assign fv[3] = a_ff[6];
   assign fu[4] = r_ff[6];  assign fv[4] = b_ff[6];

   fpmo_pkg::sq_type fd [NFIN];
   for (genvar g = 0; g < NFIN; g++) begin : g_fin
      fpmo_sqlane u_fin (
         .clock   (clock),
         .en      (advance),
         .ax      (px_ff[6][fu[g]]),
         .ay      (py_ff[6][fu[g]]),
         .bx      (px_ff[6][fv[g]]),
         .by      (py_ff[6][fv[g]]),
         .dist_ff (fd[g])
      );
   end

   // final ordering off the last stage
   logic a_near, r_near;
   fpmo_pkg::sq_type dr3;
   fpmo_pkg::idx_type p0, p2, p3, p4, p1;
   assign a_near = fd[0] < fd[1];
   assign p1     = p1_ff[DEPTH-1];
   assign p2     = a_near ? a_ff[DEPTH-1] : b_ff[DEPTH-1];
   assign p3     = a_near ? b_ff[DEPTH-1] : a_ff[DEPTH-1];
   // r to point 3 is r-b when a is point 2, else r-a
   assign dr3    = a_near ? fd[4] : fd[3];
   assign r_near = fd[2] < dr3;
   assign p0     = r_near ? r_ff[DEPTH-1] : s_ff[DEPTH-1];
   assign p4     = r_near ? s_ff[DEPTH-1] : r_ff[DEPTH-1];

   always_comb begin
      rsp_data.led0_x = px_ff[DEPTH-1][p0];
      rsp_data.led0_y = py_ff[DEPTH-1][p0];
      rsp_data.led1_x = px_ff[DEPTH-1][p1];
      rsp_data.led1_y = py_ff[DEPTH-1][p1];
      rsp_data.led2_x = px_ff[DEPTH-1][p2];
      rsp_data.led2_y = py_ff[DEPTH-1][p2];
      rsp_data.led3_x = px_ff[DEPTH-1][p3];
      rsp_data.led3_y = py_ff[DEPTH-1][p3];
      rsp_data.led4_x = px_ff[DEPTH-1][p4];
      rsp_data.led4_y = py_ff[DEPTH-1][p4];
   end

`ifndef ASSERT_OFF
   // a waiting result stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data));
   // input is taken whenever the last stage can move
   assert property (@(posedge clock) req_ready == (!rsp_valid || rsp_ready));
   // reset empties the pipe
   assert property (@(posedge clock) reset |=> !rsp_valid);
`endif
endmodule
`default_nettype wire

// ===== test/five_point_marker_ordering_tb.sv =====
// testbench for the five point marker ordering block
`timescale 1ns / 1ps
`default_nettype none
module five_point_marker_ordering_tb;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   fpmo_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   fpmo_pkg::rsp_type rsp_data;

   fpmo_pkg::rsp_type marker_queue[$];
   int      error_count = 0;
   bit      stall_enable = 1'b1;

   always #1 clock = ~clock;

   five_point_marker_ordering i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // squared distance at full width, never wraps
   function automatic logic [63:0] sq_span(fpmo_pkg::coord_type ax, fpmo_pkg::coord_type ay,
                                           fpmo_pkg::coord_type bx, fpmo_pkg::coord_type by);
      logic [63:0] dx, dy;
      dx = (ax > bx) ? 64'(ax) - 64'(bx) : 64'(bx) - 64'(ax);
      dy = (ay > by) ? 64'(ay) - 64'(by) : 64'(by) - 64'(ay);
      return dx * dx + dy * dy;
   endfunction

   // |(b-a) x (p-a)| using signed 64-bit arithmetic, ample for 16-bit coordinates
   function automatic logic [63:0] line_offset(fpmo_pkg::coord_type px[5],
                                               fpmo_pkg::coord_type py[5],
                                               int a, int b, int p);
      longint c;
      c = (longint'(px[b]) - longint'(px[a])) * (longint'(py[p]) - longint'(py[a]))
        - (longint'(py[b]) - longint'(py[a])) * (longint'(px[p]) - longint'(px[a]));
      return (c < 0) ? 64'(-c) : 64'(c);
   endfunction

   function automatic fpmo_pkg::rsp_type order_markers(fpmo_pkg::req_type w);
      fpmo_pkg::coord_type px[5], py[5];
      logic [63:0]         best, d;
      int                  a, b, k, n, p1, p2, p3, p0, p4, r, s;
      int                  rest[3];
      fpmo_pkg::rsp_type   o;
      px = '{w.x0, w.x1, w.x2, w.x3, w.x4};
      py = '{w.y0, w.y1, w.y2, w.y3, w.y4};
      // closest pair, earliest in scan order on ties
      a = 0; b = 1;
      best = sq_span(px[0], py[0], px[1], py[1]);
      for (int i = 0; i < 5; i++)
         for (int j = i + 1; j < 5; j++) begin
            d = sq_span(px[i], py[i], px[j], py[j]);
            if (d < best) begin
               best = d; a = i; b = j;
            end
         end
      n = 0;
      for (int i = 0; i < 5; i++)
         if (i != a && i != b) begin
            rest[n] = i; n++;
         end
      // point nearest the pair line, first minimum wins
      k = 0;
      best = line_offset(px, py, a, b, rest[0]);
      for (int i = 1; i < 3; i++) begin
         d = line_offset(px, py, a, b, rest[i]);
         if (d < best) begin
            best = d; k = i;
         end
      end
      p1 = rest[k];
      if (sq_span(px[p1], py[p1], px[a], py[a]) < sq_span(px[p1], py[p1], px[b], py[b])) begin
         p2 = a; p3 = b;
      end else begin
         p2 = b; p3 = a;
      end
      r = (k == 0) ? rest[1] : rest[0];
      s = (k == 2) ? rest[1] : rest[2];
      if (sq_span(px[r], py[r], px[p1], py[p1]) < sq_span(px[r], py[r], px[p3], py[p3])) begin
         p0 = r; p4 = s;
      end else begin
         p0 = s; p4 = r;
      end
      o.led0_x = px[p0]; o.led0_y = py[p0];
      o.led1_x = px[p1]; o.led1_y = py[p1];
      o.led2_x = px[p2]; o.led2_y = py[p2];
      o.led3_x = px[p3]; o.led3_y = py[p3];
      o.led4_x = px[p4]; o.led4_y = py[p4];
      return o;
   endfunction

   // sends one word, holding valid until it is taken
   task automatic send_word(fpmo_pkg::req_type w);
      req_valid <= 1'b1;
      req_data  <= w;
      marker_queue.push_back(order_markers(w));
      do @(posedge clock); while (!req_ready);
   endtask

   // drops valid between bursts
   task automatic pause_sender(int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic check_field(string name, fpmo_pkg::coord_type e, fpmo_pkg::coord_type a);
      if (e !== a) begin
         $error("%s expected %0d actual %0d", name, e, a);
         error_count++;
      end
   endtask

   // receiver stall pattern: rsp_ready drawn at random anew each cycle
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= !stall_enable || ($urandom_range(0, 15) > ($urandom_range(0, 3) * 4));
   end

   // result checker
   always @(posedge clock) begin
      fpmo_pkg::rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (marker_queue.size() == 0) begin
            $error("result word with no expectation waiting");
            error_count++;
         end else begin
            e = marker_queue.pop_front();
            check_field("led0_x", e.led0_x, rsp_data.led0_x);
            check_field("led0_y", e.led0_y, rsp_data.led0_y);
            check_field("led1_x", e.led1_x, rsp_data.led1_x);
            check_field("led1_y", e.led1_y, rsp_data.led1_y);
            check_field("led2_x", e.led2_x, rsp_data.led2_x);
            check_field("led2_y", e.led2_y, rsp_data.led2_y);
            check_field("led3_x", e.led3_x, rsp_data.led3_x);
            check_field("led3_y", e.led3_y, rsp_data.led3_y);
            check_field("led4_x", e.led4_x, rsp_data.led4_x);
            check_field("led4_y", e.led4_y, rsp_data.led4_y);
         end
      end
   end

   function automatic fpmo_pkg::req_type make_word(fpmo_pkg::coord_type p[10]);
      return {p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], p[8], p[9]};
   endfunction

   // extremes, coincident points and tie cases
   task automatic test_directed();
      fpmo_pkg::coord_type p[10];
      send_word('0);
      send_word('1);
      send_word({16'hffff, 16'h0, 16'h0, 16'hffff, 16'hffff, 16'hffff,
                 16'h0, 16'h0, 16'h8000, 16'h8000});
      // coincident pair: every cross product zero
      p = '{100, 100, 100, 100, 500, 700, 900, 50, 3000, 3000};
      send_word(make_word(p));
      // equal pair distances in scan order
      p = '{0, 0, 10, 0, 20, 0, 30, 0, 40, 0};
      send_word(make_word(p));
      // tied closest pairs, with a third point on the pair line
      p = '{0, 0, 10, 0, 5, 20, 5, 16'hffec, 5, 0};
      send_word(make_word(p));
      p = '{1000, 1000, 1010, 1000, 1005, 1040, 900, 1100, 1200, 800};
      send_word(make_word(p));
      p = '{16'hffff, 0, 0, 16'hffff, 16'hfff0, 16'h0010, 16'h0010, 16'hfff0, 16'h7fff, 16'h7fff};
      send_word(make_word(p));
      for (int i = 0; i < 16; i++) begin
         foreach (p[j]) p[j] = 16'(1 << i) ^ (j[0] ? 16'h5555 : 16'h0);
         p[3] = ~p[3];
         p[6] = 16'(i * 4099);
         send_word(make_word(p));
      end
      pause_sender(1);
   endtask

   // random point sets: marker-like layouts, full-range noise and clustered sets
   task automatic test_random(int count);
      fpmo_pkg::coord_type p[10];
      int        left, ox, oy, sc;
      left = count;
      while (left > 0) begin
         for (int n = $urandom_range(1, 20); n > 0 && left > 0; n--) begin
            case ($urandom_range(0, 3))
               0: foreach (p[j]) p[j] = 16'($urandom);
               1: begin
                  ox = $urandom_range(0, 40000); oy = $urandom_range(0, 40000);
                  foreach (p[j]) p[j] = 16'((j[0] ? oy : ox) + $urandom_range(0, 64));
               end
               default: begin
                  // rough marker: close pair, one on its line, two further out
                  ox = $urandom_range(8000, 50000); oy = $urandom_range(8000, 50000);
                  sc = $urandom_range(4, 200);
                  p = '{16'(ox - 3*sc), 16'(oy + 2*sc), 16'(ox), 16'(oy),
                        16'(ox + sc), 16'(oy), 16'(ox + 3*sc), 16'(oy + $urandom_range(0, 8)),
                        16'(ox + $urandom_range(0, 4*sc)), 16'(oy - 3*sc)};
                  p[$urandom_range(0, 9)] ^= 16'($urandom_range(0, 3));
               end
            endcase
            send_word(make_word(p));
            left--;
         end
         if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
      end
      pause_sender(1);
   endtask

   task automatic drain();
      while (marker_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(300);
      stall_enable = 1'b0; // full-rate stretch with no stalls
      test_random(250);
      stall_enable = 1'b1;
      test_random(300);
      drain();
      if (error_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   initial begin
      #200000;
      $display("TB_ERROR");
      $finish;
   end
endmodule
`default_nettype wire
